// ----- rtl/bpc_pkg.sv -----
// bpc_pkg: shared types, constants and helpers for the pressure compensation core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
    localparam logic [1:0] REG_PRESS_CAL_A = 2'd1;
    localparam logic [1:0] REG_PRESS_CAL_B = 2'd2;
    localparam logic [1:0] REG_OSS_MODE    = 2'd3;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // formula constants
    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] P_SQ_COEF  = 32'd3038;
    localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E343;   // -7357
    localparam logic [31:0] P_BIAS     = 32'd3791;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;

    // 32-bit divider width
    localparam int DIV_W = 32;

    // calibration set handed to the datapath
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] mc;
        logic [31:0] md;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [1:0]  oss;
    } cal_t;

    // sign extension of a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    // arithmetic shift right on a 32-bit pattern
    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        asr = 32'($signed(x) >>> n);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bpc_div_stage.sv -----
// bpc_div_stage: one restoring step of an unsigned 32-bit divider
// depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bpc_div_stage (
    input  wire logic [bpc_pkg::DIV_W-1:0] rem_in,
    input  wire logic [bpc_pkg::DIV_W-1:0] num_in,
    input  wire logic [bpc_pkg::DIV_W-1:0] den,
    output logic      [bpc_pkg::DIV_W-1:0] rem_out,
    output logic      [bpc_pkg::DIV_W-1:0] num_out
);
    import bpc_pkg::*;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] shifted;

    // shift in next numerator bit and try a subtract
    always_comb
    begin
        shifted = {rem_in, num_in[DIV_W-1]};
        trial   = shifted - {1'b0, den};
        if (!trial[DIV_W])
        begin
            rem_out = trial[DIV_W-1:0];
            num_out = {num_in[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_out = shifted[DIV_W-1:0];
            num_out = {num_in[DIV_W-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bpc_divider.sv -----
// bpc_divider: pipelined unsigned 32/32 divider, one quotient bit per stage
// with a side payload carried alongside; depends on bpc_pkg, bpc_div_stage
`timescale 1ns / 1ps
`default_nettype none
module bpc_divider #(
    parameter int SIDE_W = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [bpc_pkg::DIV_W-1:0] num,
    input  wire logic [bpc_pkg::DIV_W-1:0] den,
    input  wire logic [SIDE_W-1:0]         side_in,
    output logic                           out_valid,
    output logic      [bpc_pkg::DIV_W-1:0] quo,
    output logic      [SIDE_W-1:0]         side_out
);
    import bpc_pkg::*;

    logic [DIV_W-1:0]  rem_reg  [DIV_W+1];
    logic [DIV_W-1:0]  num_reg  [DIV_W+1];
    logic [DIV_W-1:0]  den_reg  [DIV_W+1];
    logic [SIDE_W-1:0] side_reg [DIV_W+1];
    logic              vld_reg  [DIV_W+1];

    // stage zero captures the operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            num_reg[0]  <= num;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < DIV_W; i++)
    begin : g_step
        logic [DIV_W-1:0] rem_next;
        logic [DIV_W-1:0] num_next;

        bpc_div_stage u_stage (
            .rem_in  (rem_reg[i]),
            .num_in  (num_reg[i]),
            .den     (den_reg[i]),
            .rem_out (rem_next),
            .num_out (num_next)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                num_reg[i+1]  <= num_next;
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[DIV_W];
    assign quo       = num_reg[DIV_W];
    assign side_out  = side_reg[DIV_W];
endmodule
`default_nettype wire

// ----- rtl/bpc_cfg_regs.sv -----
// bpc_cfg_regs: calibration and mode registers with unpacked coefficient view
// depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bpc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0] wr_data,
    output bpc_pkg::cal_t                       cal
);
    import bpc_pkg::*;

    logic [63:0] temp_cal_reg;
    logic [63:0] press_cal_a_reg;
    logic [31:0] press_cal_b_reg;
    logic [1:0]  oss_mode_reg;
    logic        idx_ok;

    assign idx_ok = (wr_index[CFG_IDX_W-1:2] == '0);

    // register writes, indexes beyond the list ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg    <= '0;
            press_cal_a_reg <= '0;
            press_cal_b_reg <= '0;
            oss_mode_reg    <= '0;
        end
        else if (wr_en && idx_ok)
        begin
            unique case (wr_index[1:0])
                REG_TEMP_CAL:    temp_cal_reg    <= wr_data;
                REG_PRESS_CAL_A: press_cal_a_reg <= wr_data;
                REG_PRESS_CAL_B: press_cal_b_reg <= wr_data[31:0];
                REG_OSS_MODE:    oss_mode_reg    <= wr_data[1:0];
                default:         ;
            endcase
        end
    end

    // coefficient view
    always_comb
    begin
        cal.ac5 = {16'd0, temp_cal_reg[63:48]};
        cal.ac6 = {16'd0, temp_cal_reg[47:32]};
        cal.mc  = sx16(temp_cal_reg[31:16]);
        cal.md  = sx16(temp_cal_reg[15:0]);
        cal.ac4 = {16'd0, press_cal_a_reg[63:48]};
        cal.ac3 = sx16(press_cal_a_reg[47:32]);
        cal.ac2 = sx16(press_cal_a_reg[31:16]);
        cal.ac1 = sx16(press_cal_a_reg[15:0]);
        cal.b2  = sx16(press_cal_b_reg[31:16]);
        cal.b1  = sx16(press_cal_b_reg[15:0]);
        cal.oss = oss_mode_reg;
    end
endmodule
`default_nettype wire

// ----- rtl/barometric_pressure_compensation_core.sv -----
// barometric_pressure_compensation_core: top level of the compensation pipeline
// two 33-stage dividers, one for the temperature divide and one for the pressure divide
// throughput: one word per cycle; the whole pipeline stalls only when the output
// register is full and not taken
// reset: rst_n clears all valid bits and the calibration registers to zero
// depends on bpc_pkg, bpc_cfg_regs, bpc_divider
`timescale 1ns / 1ps
`default_nettype none
module barometric_pressure_compensation_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [15:0] raw_temp, [34:16] raw_press
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] temp_tenths, [63:32] pressure_pa
    output logic             m_axis_tuser    // [0] div_fault
);
    import bpc_pkg::*;

    localparam int SIDE1_W = 32 + 19 + 1 + 1;   // x1, up, den zero, num sign ^ den sign
    localparam int SIDE2_W = 32 + 1 + 1;        // temp, fault, b7 high bit

    cal_t cal;
    logic en;

    assign cfg_ready = 1'b1;

    bpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cal      (cal)
    );

    // output register; pipeline advances when it is free or being taken
    logic        out_vld_reg;
    logic [63:0] out_data_reg;
    logic        out_user_reg;
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage a: x1 product
    logic        a_vld_reg;
    logic [31:0] a_prod_reg;
    logic [18:0] a_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= ({16'd0, s_axis_tdata[15:0]} - cal.ac6) * cal.ac5;
            a_up_reg   <= s_axis_tdata[34:16];
        end
    end

    // stage b: divisor and numerator magnitudes for temperature divide
    logic        b_vld_reg;
    logic [31:0] b_x1_reg;
    logic [31:0] b_num_reg;
    logic [31:0] b_den_reg;
    logic        b_dz_reg;
    logic        b_neg_reg;
    logic [18:0] b_up_reg;
    logic [31:0] b_x1;
    logic [31:0] b_den;
    logic [31:0] b_mcs;
    assign b_x1  = asr(a_prod_reg, 15);
    assign b_den = b_x1 + cal.md;
    assign b_mcs = cal.mc << 11;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x1_reg  <= b_x1;
            b_num_reg <= b_mcs[31] ? 32'(0 - b_mcs) : b_mcs;
            b_den_reg <= b_den[31] ? 32'(0 - b_den) : b_den;
            b_dz_reg  <= (b_den == '0);
            b_neg_reg <= b_mcs[31] ^ b_den[31];
            b_up_reg  <= a_up_reg;
        end
    end

    // temperature divide
    logic              d1_vld;
    logic [31:0]       d1_quo;
    logic [SIDE1_W-1:0] d1_side;
    bpc_divider #(.SIDE_W(SIDE1_W)) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld_reg),
        .num       (b_num_reg),
        .den       (b_den_reg),
        .side_in   ({b_x1_reg, b_up_reg, b_dz_reg, b_neg_reg}),
        .out_valid (d1_vld),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    // stage c: b5, temp, b6
    logic        c_vld_reg;
    logic [31:0] c_temp_reg;
    logic [31:0] c_b6_reg;
    logic        c_dz_reg;
    logic [18:0] c_up_reg;
    logic [31:0] c_x2;
    logic [31:0] c_b5;
    assign c_x2 = d1_side[0] ? 32'(0 - d1_quo) : d1_quo;
    assign c_b5 = d1_side[SIDE1_W-1 -: 32] + c_x2;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= d1_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_temp_reg <= asr(c_b5 + 32'd8, 4);
            c_b6_reg   <= c_b5 - B6_OFFSET;
            c_dz_reg   <= d1_side[1];
            c_up_reg   <= d1_side[20:2];
        end
    end

    // stage d: b6 squared, ac2*b6, ac3*b6
    logic        d_vld_reg;
    logic [31:0] d_sq_reg, d_ac2_reg, d_ac3_reg, d_b6_reg, d_temp_reg;
    logic        d_dz_reg;
    logic [18:0] d_up_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= c_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_sq_reg   <= c_b6_reg * c_b6_reg;
            d_ac2_reg  <= cal.ac2 * c_b6_reg;
            d_ac3_reg  <= cal.ac3 * c_b6_reg;
            d_b6_reg   <= c_b6_reg;
            d_temp_reg <= c_temp_reg;
            d_dz_reg   <= c_dz_reg;
            d_up_reg   <= c_up_reg;
        end
    end

    // stage e: b2*b6sq, b1*b6sq
    logic        e_vld_reg;
    logic [31:0] e_b2p_reg, e_b1p_reg, e_ac2_reg, e_ac3_reg, e_temp_reg;
    logic        e_dz_reg;
    logic [18:0] e_up_reg;
    logic [31:0] e_sq;
    assign e_sq = asr(d_sq_reg, 12);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= d_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_b2p_reg  <= cal.b2 * e_sq;
            e_b1p_reg  <= cal.b1 * e_sq;
            e_ac2_reg  <= d_ac2_reg;
            e_ac3_reg  <= d_ac3_reg;
            e_temp_reg <= d_temp_reg;
            e_dz_reg   <= d_dz_reg;
            e_up_reg   <= d_up_reg;
        end
    end

    // stage f: b3 and x3 for b4
    logic        f_vld_reg;
    logic [31:0] f_b3_reg, f_x3_reg, f_temp_reg;
    logic        f_dz_reg;
    logic [18:0] f_up_reg;
    logic [31:0] f_x3a, f_b3n, f_x3b;
    always_comb
    begin
        f_x3a = asr(e_b2p_reg, 11) + asr(e_ac2_reg, 11);
        f_b3n = ((cal.ac1 * 32'd4 + f_x3a) << cal.oss) + 32'd2;
        f_x3b = asr(asr(e_ac3_reg, 13) + asr(e_b1p_reg, 16) + 32'd2, 2);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (en)
            f_vld_reg <= e_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // signed divide by four truncating toward zero
            f_b3_reg   <= f_b3n[31] ? asr(f_b3n + 32'd3, 2) : asr(f_b3n, 2);
            f_x3_reg   <= f_x3b + B4_BIAS;
            f_temp_reg <= e_temp_reg;
            f_dz_reg   <= e_dz_reg;
            f_up_reg   <= e_up_reg;
        end
    end

    // stage g: b4 product and b7 product
    logic        g_vld_reg;
    logic [31:0] g_b4p_reg, g_b7_reg, g_temp_reg;
    logic        g_dz_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (en)
            g_vld_reg <= f_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_b4p_reg  <= cal.ac4 * f_x3_reg;
            g_b7_reg   <= ({13'd0, f_up_reg} - f_b3_reg) * (B7_SCALE >> cal.oss);
            g_temp_reg <= f_temp_reg;
            g_dz_reg   <= f_dz_reg;
        end
    end

    // stage h: divider operands for pressure
    logic        h_vld_reg;
    logic [31:0] h_num_reg, h_den_reg, h_temp_reg;
    logic        h_fault_reg, h_hi_reg;
    logic [31:0] h_b4;
    assign h_b4 = g_b4p_reg >> 15;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (en)
            h_vld_reg <= g_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_num_reg   <= g_b7_reg[31] ? g_b7_reg : {g_b7_reg[30:0], 1'b0};
            h_den_reg   <= h_b4;
            h_hi_reg    <= g_b7_reg[31];
            h_fault_reg <= g_dz_reg || (h_b4 == '0);
            h_temp_reg  <= g_temp_reg;
        end
    end

    // pressure divide
    logic               d2_vld;
    logic [31:0]        d2_quo;
    logic [SIDE2_W-1:0] d2_side;
    bpc_divider #(.SIDE_W(SIDE2_W)) u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_vld_reg),
        .num       (h_num_reg),
        .den       (h_den_reg),
        .side_in   ({h_temp_reg, h_fault_reg, h_hi_reg}),
        .out_valid (d2_vld),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    // stage i: p and p>>8 squared
    logic        i_vld_reg;
    logic [31:0] i_p_reg, i_sq_reg, i_temp_reg;
    logic        i_fault_reg;
    logic [31:0] i_p, i_ps;
    assign i_p  = d2_side[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
    assign i_ps = asr(i_p, 8);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_vld_reg <= 1'b0;
        else if (en)
            i_vld_reg <= d2_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_p_reg     <= i_p;
            i_sq_reg    <= i_ps * i_ps;
            i_temp_reg  <= d2_side[SIDE2_W-1 -: 32];
            i_fault_reg <= d2_side[1];
        end
    end

    // stage j: coefficient products
    logic        j_vld_reg;
    logic [31:0] j_x1_reg, j_x2_reg, j_p_reg, j_temp_reg;
    logic        j_fault_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_vld_reg <= 1'b0;
        else if (en)
            j_vld_reg <= i_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_x1_reg    <= i_sq_reg * P_SQ_COEF;
            j_x2_reg    <= P_LIN_COEF * i_p_reg;
            j_p_reg     <= i_p_reg;
            j_temp_reg  <= i_temp_reg;
            j_fault_reg <= i_fault_reg;
        end
    end

    // output register
    logic [31:0] k_p;
    assign k_p = j_p_reg + asr(asr(j_x1_reg, 16) + asr(j_x2_reg, 16) + P_BIAS, 4);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= j_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= j_fault_reg ? 64'd0 : {k_p, j_temp_reg};
            out_user_reg <= j_fault_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // a faulted word carries zero results
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("fault word with nonzero data");

    // a held output word is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

    // input side is ready whenever the output register drains
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("pipeline stalled with output taken");

endmodule
`default_nettype wire

// ----- tb/barometric_pressure_compensation_core_tb.sv -----
// barometric_pressure_compensation_core_tb: self-checking bench for the compensation core
// directed rows then random calibration sets and readings, checked against a local model
// depends on bpc_pkg and barometric_pressure_compensation_core
`timescale 1ns / 1ps
module barometric_pressure_compensation_core_tb;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RAND_PHASES    = 8;
    localparam int WORDS_PER_PHASE = 190;
    localparam logic [7:0] REG_UNUSED = 8'd5;

    typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  idx;
        logic [63:0] data;
        logic [15:0] ut;
        logic [18:0] up;
        bit          typed;
        logic [31:0] t_exp;
        logic [31:0] p_exp;
        logic        f_exp;
    } row_t;

    typedef struct {
        logic [31:0] temp_tenths;
        logic [31:0] pressure_pa;
        logic        div_fault;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    // local copy of the calibration registers
    logic [63:0] temp_cal;
    logic [63:0] press_cal_a;
    logic [31:0] press_cal_b;
    logic [1:0]  oss_mode;

    reading_t pending_readings[$];
    int       errors;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_stall_pct;
    row_t     rows[$];

    barometric_pressure_compensation_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        sra32 = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    // truncating signed quotient, nonzero divisor
    function automatic logic [31:0] trunc_quot(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? 32'd0 - a : a;
        mb = b[31] ? 32'd0 - b : b;
        q = ma / mb;
        trunc_quot = (a[31] != b[31]) ? 32'd0 - q : q;
    endfunction

    // compensated temperature and pressure for one reading pair
    function automatic reading_t compensate(input logic [15:0] ut_raw, input logic [18:0] up_raw);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
        logic [31:0] x1, x2, x3, den, b5, b6, b6sq, b3, b4, b7, p, tt;
        int oss;
        ac5 = {16'd0, temp_cal[63:48]};
        ac6 = {16'd0, temp_cal[47:32]};
        mc  = sext16(temp_cal[31:16]);
        md  = sext16(temp_cal[15:0]);
        ac4 = {16'd0, press_cal_a[63:48]};
        ac3 = sext16(press_cal_a[47:32]);
        ac2 = sext16(press_cal_a[31:16]);
        ac1 = sext16(press_cal_a[15:0]);
        b2  = sext16(press_cal_b[31:16]);
        b1  = sext16(press_cal_b[15:0]);
        oss = oss_mode;
        r = '{32'd0, 32'd0, 1'b1};
        // temperature
        x1 = sra32(({16'd0, ut_raw} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 32'd0)
            return r;
        x2 = trunc_quot(mc << 11, den);
        b5 = x1 + x2;
        tt = sra32(b5 + 32'd8, 4);
        // pressure
        b6 = b5 - B6_OFFSET;
        b6sq = sra32(b6 * b6, 12);
        x3 = sra32(b2 * b6sq, 11) + sra32(ac2 * b6, 11);
        b3 = trunc_quot(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
        x1 = sra32(ac3 * b6, 13);
        x2 = sra32(b1 * b6sq, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + B4_BIAS)) >> 15;
        if (b4 == 32'd0)
            return r;
        b7 = ({13'd0, up_raw} - b3) * (B7_SCALE >> oss);
        if (!b7[31])
            p = (b7 * 32'd2) / b4;
        else
            p = (b7 / b4) * 32'd2;
        x1 = sra32(p, 8) * sra32(p, 8);
        x1 = sra32(x1 * P_SQ_COEF, 16);
        x2 = sra32(P_LIN_COEF * p, 16);
        p = p + sra32(x1 + x2 + P_BIAS, 4);
        r = '{tt, p, 1'b0};
        return r;
    endfunction

    // watchdog and output checker
    always @(posedge clk)
    begin
        reading_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("barometric_pressure_compensation_core_tb failed");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word %h fault %b", $time, m_axis_tdata,
                             m_axis_tuser);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (m_axis_tdata[31:0] !== want.temp_tenths)
                    begin
                        errors++;
                        $display("%0t: temp_tenths expected %0d got %0d", $time,
                                 $signed(want.temp_tenths), $signed(m_axis_tdata[31:0]));
                    end
                    if (m_axis_tdata[63:32] !== want.pressure_pa)
                    begin
                        errors++;
                        $display("%0t: pressure_pa expected %0d got %0d", $time,
                                 $signed(want.pressure_pa), $signed(m_axis_tdata[63:32]));
                    end
                    if (m_axis_tuser !== want.div_fault)
                    begin
                        errors++;
                        $display("%0t: div_fault expected %b got %b", $time,
                                 want.div_fault, m_axis_tuser);
                    end
                end
            end
            m_axis_tready <= !($urandom_range(99) < recv_stall_pct);
        end
    end

    // wait for the pipeline to empty, then some margin
    task automatic wait_drained();
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == {6'd0, REG_TEMP_CAL})
            temp_cal = data;
        else if (idx == {6'd0, REG_PRESS_CAL_A})
            press_cal_a = data;
        else if (idx == {6'd0, REG_PRESS_CAL_B})
            press_cal_b = data[31:0];
        else if (idx == {6'd0, REG_OSS_MODE})
            oss_mode = data[1:0];
    endtask

    // send one reading pair, queue its expected result on acceptance
    task automatic send_word(input logic [15:0] ut, input logic [18:0] up,
                             input bit typed, input reading_t typed_exp);
        reading_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, up, ut};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = typed ? typed_exp : compensate(ut, up);
        pending_readings.push_back(r);
    endtask

    function automatic row_t cfg_row(input logic [7:0] idx, input logic [63:0] data);
        cfg_row = '{ROW_CFG, idx, data, 16'd0, 19'd0, 1'b0, 32'd0, 32'd0, 1'b0};
    endfunction

    function automatic row_t word_row(input logic [15:0] ut, input logic [18:0] up,
                                      input bit typed, input logic [31:0] t,
                                      input logic [31:0] p, input logic f);
        word_row = '{ROW_WORD, 8'd0, 64'd0, ut, up, typed, t, p, f};
    endfunction

    // stimulus
    initial
    begin
        row_t        row;
        logic [15:0] ut;
        logic [18:0] up;
        logic [63:0] cal;
        int          mode;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 8'd0;
        cfg_data = 64'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 40'd0;
        m_axis_tready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        temp_cal = 64'd0;
        press_cal_a = 64'd0;
        press_cal_b = 32'd0;
        oss_mode = 2'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero calibration after reset: temperature divisor is zero
        rows.push_back(word_row(16'h0000, 19'h00000, 1, 32'd0, 32'd0, 1'b1));
        rows.push_back(word_row(16'hFFFF, 19'h7FFFF, 1, 32'd0, 32'd0, 1'b1));
        rows.push_back(cfg_row(REG_UNUSED, '1));
        rows.push_back(word_row(16'h1234, 19'h00001, 1, 32'd0, 32'd0, 1'b1));
        // datasheet example coefficients
        rows.push_back(cfg_row({6'd0, REG_TEMP_CAL},
                               {16'd32757, 16'd23153, 16'hDDF9, 16'd2868}));
        rows.push_back(cfg_row({6'd0, REG_PRESS_CAL_A},
                               {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408}));
        rows.push_back(cfg_row({6'd0, REG_PRESS_CAL_B}, {32'hDEAD_BEEF, 16'd4, 16'd6190}));
        rows.push_back(cfg_row({6'd0, REG_OSS_MODE}, 64'hFFFF_FFFF_FFFF_FFFC));
        rows.push_back(word_row(16'd27898, 19'd23843, 1, 32'd150, 32'd69964, 1'b0));
        rows.push_back(word_row(16'h0000, 19'h00000, 0, 32'd0, 32'd0, 1'b0));
        rows.push_back(word_row(16'hFFFF, 19'h7FFFF, 0, 32'd0, 32'd0, 1'b0));
        rows.push_back(word_row(16'hFFFF, 19'h00000, 0, 32'd0, 32'd0, 1'b0));
        rows.push_back(word_row(16'h0000, 19'h7FFFF, 0, 32'd0, 32'd0, 1'b0));
        rows.push_back(cfg_row({6'd0, REG_OSS_MODE}, 64'd3));
        rows.push_back(word_row(16'd27898, 19'd190744, 0, 32'd0, 32'd0, 1'b0));
        rows.push_back(word_row(16'hFFFF, 19'h7FFFF, 0, 32'd0, 32'd0, 1'b0));
        // ac4 zero: pressure divisor is zero
        rows.push_back(cfg_row({6'd0, REG_PRESS_CAL_A}, {16'd0, 16'hC7D1, 16'hFFB8, 16'd408}));
        rows.push_back(word_row(16'd27898, 19'd23843, 1, 32'd0, 32'd0, 1'b1));
        // ac5 and md zero: temperature divisor is zero
        rows.push_back(cfg_row({6'd0, REG_TEMP_CAL}, {16'd0, 16'd23153, 16'hDDF9, 16'd0}));
        rows.push_back(word_row(16'd27898, 19'd23843, 1, 32'd0, 32'd0, 1'b1));

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.data);
            else
                send_word(row.ut, row.up, row.typed, '{row.t_exp, row.p_exp, row.f_exp});
        end

        // random calibration sets (all ones in phase 5), idling pattern cycles through the phases
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            mode = ph % 4;
            if (ph == 5)
            begin
                write_reg({6'd0, REG_TEMP_CAL}, '1);
                write_reg({6'd0, REG_PRESS_CAL_A}, '1);
                write_reg({6'd0, REG_PRESS_CAL_B}, '1);
            end
            else if (ph % 2 == 0)
            begin
                // near the typical factory values
                cal = {16'd32757, 16'd23153, 16'hDDF9, 16'd2868};
                cal[47:32] = cal[47:32] + 16'($urandom_range(2000)) - 16'd1000;
                cal[15:0] = cal[15:0] + 16'($urandom_range(600)) - 16'd300;
                write_reg({6'd0, REG_TEMP_CAL}, cal);
                cal = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
                cal[15:0] = cal[15:0] + 16'($urandom_range(200)) - 16'd100;
                write_reg({6'd0, REG_PRESS_CAL_A}, cal);
                write_reg({6'd0, REG_PRESS_CAL_B},
                          {$urandom, 16'($urandom_range(8)), 16'd6190});
            end
            else
            begin
                write_reg({6'd0, REG_TEMP_CAL}, {$urandom, $urandom});
                write_reg({6'd0, REG_PRESS_CAL_A}, {$urandom, $urandom});
                write_reg({6'd0, REG_PRESS_CAL_B}, {$urandom, $urandom});
            end
            write_reg({6'd0, REG_OSS_MODE}, {$urandom, $urandom} & ~64'd3 | 64'(ph % 4));
            send_idle_pct  = (mode == 1) ? 86 : (mode == 3) ? 33 : 0;
            recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 33 : 0;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if ($urandom_range(99) < 60)
                begin
                    ut = 16'd27898 + 16'($urandom_range(8000)) - 16'd4000;
                    up = 19'(($urandom_range(30000) + 15000) << oss_mode);
                end
                else
                begin
                    ut = 16'($urandom);
                    up = 19'($urandom);
                end
                // hold off once until the pipeline has emptied
                if (ph == 1 && n == WORDS_PER_PHASE / 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_readings.size() != 0)
                        @(posedge clk);
                end
                send_word(ut, up, 0, '{32'd0, 32'd0, 1'b0});
            end
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        wait_drained();

        if (errors == 0 && pending_readings.size() == 0)
            $display("barometric_pressure_compensation_core_tb passed");
        else
            $display("barometric_pressure_compensation_core_tb failed");
        $finish;
    end

endmodule
